// ===== rtl/core/pr_pkg.sv =====
`default_nettype none

package pr_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [1:0] {
        REG_START_X = 2'd0,
        REG_START_Y = 2'd1,
        REG_END_X   = 2'd2,
        REG_END_Y   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/pr_point_if.sv =====
`default_nettype none

interface pr_point_if
    import pr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pr_result_if.sv =====
`default_nettype none

interface pr_result_if
    import pr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] mirrored_x;
    logic signed [COORD_BITS-1:0] mirrored_y;
    logic                         end_of_shape;
    logic                         clipped;

    modport source (output valid, mirrored_x, mirrored_y, end_of_shape, clipped, input ready);
    modport sink   (input valid, mirrored_x, mirrored_y, end_of_shape, clipped, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pr_front.sv =====
`default_nettype none

module pr_front
    import pr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire logic                  in_valid,
    input  wire logic [COORD_BITS-1:0] point_x,
    input  wire logic [COORD_BITS-1:0] point_y,
    input  wire logic                  last_point,
    input  wire logic [COORD_BITS-1:0] start_x,
    input  wire logic [COORD_BITS-1:0] start_y,
    input  wire logic [COORD_BITS-1:0] end_x,
    input  wire logic [COORD_BITS-1:0] end_y,
    output logic                       out_valid,
    output logic [3*COORD_BITS+5+3*COORD_BITS+5+2*COORD_BITS+2+2*COORD_BITS+3+COORD_BITS+2+1-1:0]
                                       out_entry
);
    localparam int C  = COORD_BITS;
    localparam int NB = 3*C + 5;
    localparam int NW = 2*C + 2;
    localparam int VW = C + 2;

    // stage 1: differences and line direction
    logic signed [C:0]    a1_reg, b1_reg, dx1_reg, dy1_reg;
    logic signed [C:0]    a1_next, b1_next, dx1_next, dy1_next;
    logic signed [VW-1:0] vx1_reg, vx1_next;
    logic [C-1:0]         px1_reg, py1_reg;
    logic                 vert1_reg, last1_reg;

    // stage 2: products
    logic signed [2*C+1:0] pa2_reg, pb2_reg, aa2_reg, bb2_reg;
    logic signed [2*C+1:0] pa2_next, pb2_next, aa2_next, bb2_next;
    logic signed [C:0]     a2_reg, b2_reg;
    logic signed [VW-1:0]  vx2_reg;
    logic [C-1:0]          px2_reg, py2_reg;
    logic                  vert2_reg, last2_reg;

    // stage 3: distance term and norm
    logic signed [2*C+3:0] sum3, d3_reg, d3_next;
    logic [NW-1:0]         den3_reg, den3_next;
    logic signed [C:0]     a3_reg, b3_reg;
    logic signed [VW-1:0]  vx3_reg;
    logic [C-1:0]          px3_reg, py3_reg;
    logic                  vert3_reg, last3_reg;

    // stage 4: numerators
    logic [2*C+3:0]        td4;
    logic [C:0]            ma4, mb4;
    logic [NB-1:0]         numx4_reg, numy4_reg, numx4_next, numy4_next;
    logic [NW-1:0]         den4_reg;
    logic signed [VW-1:0]  vx4_reg;
    logic [C-1:0]          px4_reg, py4_reg;
    logic                  posx4_reg, posy4_reg, vert4_reg, last4_reg;

    logic [3:0]            vld_reg;

    assign a1_next  = {end_y[C-1], end_y} - {start_y[C-1], start_y};
    assign b1_next  = {start_x[C-1], start_x} - {end_x[C-1], end_x};
    assign dx1_next = {point_x[C-1], point_x} - {start_x[C-1], start_x};
    assign dy1_next = {point_y[C-1], point_y} - {start_y[C-1], start_y};
    assign vx1_next = {start_x[C-1], start_x, 1'b0} - {{2{point_x[C-1]}}, point_x};

    assign pa2_next = a1_reg * dx1_reg;
    assign pb2_next = b1_reg * dy1_reg;
    assign aa2_next = a1_reg * a1_reg;
    assign bb2_next = b1_reg * b1_reg;

    assign sum3      = (2*C+4)'(pa2_reg) + (2*C+4)'(pb2_reg);
    assign d3_next   = sum3 <<< 1;
    assign den3_next = NW'(aa2_reg[2*C:0]) + NW'(bb2_reg[2*C:0]);

    assign td4        = d3_reg[2*C+3] ? (2*C+4)'(-d3_reg) : d3_reg;
    assign ma4        = a3_reg[C] ? (C+1)'(-a3_reg) : a3_reg;
    assign mb4        = b3_reg[C] ? (C+1)'(-b3_reg) : b3_reg;
    assign numx4_next = ma4 * td4;
    assign numy4_next = mb4 * td4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a1_reg    <= a1_next;
            b1_reg    <= b1_next;
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            vx1_reg   <= vx1_next;
            px1_reg   <= point_x;
            py1_reg   <= point_y;
            vert1_reg <= (start_x == end_x);
            last1_reg <= last_point;

            pa2_reg   <= pa2_next;
            pb2_reg   <= pb2_next;
            aa2_reg   <= aa2_next;
            bb2_reg   <= bb2_next;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            vx2_reg   <= vx1_reg;
            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
            vert2_reg <= vert1_reg;
            last2_reg <= last1_reg;

            d3_reg    <= d3_next;
            den3_reg  <= den3_next;
            a3_reg    <= a2_reg;
            b3_reg    <= b2_reg;
            vx3_reg   <= vx2_reg;
            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
            vert3_reg <= vert2_reg;
            last3_reg <= last2_reg;

            numx4_reg <= numx4_next;
            numy4_reg <= numy4_next;
            den4_reg  <= den3_reg;
            posx4_reg <= (a3_reg[C] == d3_reg[2*C+3]);
            posy4_reg <= (b3_reg[C] == d3_reg[2*C+3]);
            vx4_reg   <= vx3_reg;
            px4_reg   <= px3_reg;
            py4_reg   <= py3_reg;
            vert4_reg <= vert3_reg;
            last4_reg <= last3_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_entry = {numx4_reg, numy4_reg, den4_reg, px4_reg, py4_reg,
                        posx4_reg, posy4_reg, vert4_reg, vx4_reg, last4_reg};

endmodule

`default_nettype wire

// ===== rtl/core/pr_queue.sv =====
`default_nettype none

module pr_queue
    import pr_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output queue_stat_t           stat
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [0:QUEUE_DEPTH-1];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= wdata;
        end
    end

    assign rdata      = slot_reg[rd_reg];
    assign stat.full  = (cnt_reg == CW'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

`default_nettype wire

// ===== rtl/core/pr_back.sv =====
`default_nettype none

module pr_back
    import pr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire logic [3*COORD_BITS+5+3*COORD_BITS+5+2*COORD_BITS+2+2*COORD_BITS+3+COORD_BITS+2+1-1:0]
                                       q_entry,
    output logic                       q_pop,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic [COORD_BITS-1:0]      mirrored_x,
    output logic [COORD_BITS-1:0]      mirrored_y,
    output logic                       end_of_shape,
    output logic                       clipped
);
    localparam int C  = COORD_BITS;
    localparam int NB = 3*C + 5;
    localparam int NW = 2*C + 2;
    localparam int VW = C + 2;
    localparam int QB = C + 4;
    localparam int SW = NW + 2*C + 3 + VW + 1;
    localparam int RW = QB + 3;
    localparam longint CMAX_L = (longint'(1) << (C - 1)) - 1;
    localparam longint CMIN_L = -CMAX_L - 1;

    logic            en;
    logic [NW:0]     rx_reg   [0:QB];
    logic [NW:0]     ry_reg   [0:QB];
    logic [QB-1:0]   lx_reg   [0:QB];
    logic [QB-1:0]   ly_reg   [0:QB];
    logic [QB-1:0]   qx_reg   [0:QB];
    logic [QB-1:0]   qy_reg   [0:QB];
    logic [SW-1:0]   side_reg [0:QB];
    logic [QB:0]     vld_reg;

    logic [NW:0]     rx_nx [1:QB];
    logic [NW:0]     ry_nx [1:QB];
    logic            gx    [1:QB];
    logic            gy    [1:QB];

    logic [NB-1:0]   numx_in, numy_in;
    logic [NW-1:0]   den_f, rmx, rmy;
    logic [C-1:0]    px_f, py_f;
    logic            posx_f, posy_f, vert_f, last_f;
    logic [VW-1:0]   vx_f;
    logic signed [RW-1:0] resx, resy;
    logic [C:0]      clx, cly;

    logic [C-1:0]    mx_reg, my_reg;
    logic            eos_reg, clip_reg, rvalid_reg;

    function automatic logic signed [RW-1:0] round_coord(
        input logic [C-1:0]  v,
        input logic [QB-1:0] q,
        input logic [NW-1:0] rm,
        input logic [NW-1:0] n,
        input logic          pos
    );
        logic signed [RW-1:0] base;
        logic                 over, half, adj;
        over = {rm, 1'b0} > {1'b0, n};
        half = {rm, 1'b0} >= {1'b0, n};
        if (pos)
        begin
            base = RW'($signed(v)) - $signed(RW'(q));
            adj  = (base <= 0) ? half : over;
            if (rm != '0)
            begin
                base = base - $signed(RW'(adj));
            end
        end
        else
        begin
            base = RW'($signed(v)) + $signed(RW'(q));
            adj  = (base >= 0) ? half : over;
            if (rm != '0)
            begin
                base = base + $signed(RW'(adj));
            end
        end
        return base;
    endfunction

    // returns {clip, value}
    function automatic logic [C:0] clamp(input logic signed [RW-1:0] r);
        logic [C:0] res;
        if (r > CMAX_L)
        begin
            res = {1'b1, 1'b0, {(C-1){1'b1}}};
        end
        else if (r < CMIN_L)
        begin
            res = {1'b1, 1'b1, {(C-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, r[C-1:0]};
        end
        return res;
    endfunction

    assign en      = !rvalid_reg || res_ready;
    assign q_pop   = en && q_valid;
    assign numx_in = q_entry[SW+2*NB-1 -: NB];
    assign numy_in = q_entry[SW+NB-1 -: NB];

    // one quotient bit per stage
    for (genvar k = 1; k <= QB; k++)
    begin : g_div
        logic [NW:0]   shx, shy, dn;
        assign dn    = {1'b0, side_reg[k-1][SW-1 -: NW]};
        assign shx   = {rx_reg[k-1][NW-1:0], lx_reg[k-1][QB-1]};
        assign shy   = {ry_reg[k-1][NW-1:0], ly_reg[k-1][QB-1]};
        assign gx[k] = (shx >= dn);
        assign gy[k] = (shy >= dn);
        assign rx_nx[k] = gx[k] ? shx - dn : shx;
        assign ry_nx[k] = gy[k] ? shy - dn : shy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QB-1:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0]   <= (NW+1)'(numx_in[NB-1:QB]);
            ry_reg[0]   <= (NW+1)'(numy_in[NB-1:QB]);
            lx_reg[0]   <= numx_in[QB-1:0];
            ly_reg[0]   <= numy_in[QB-1:0];
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            side_reg[0] <= q_entry[SW-1:0];
            for (int k = 1; k <= QB; k++)
            begin
                rx_reg[k]   <= rx_nx[k];
                ry_reg[k]   <= ry_nx[k];
                lx_reg[k]   <= lx_reg[k-1] << 1;
                ly_reg[k]   <= ly_reg[k-1] << 1;
                qx_reg[k]   <= {qx_reg[k-1][QB-2:0], gx[k]};
                qy_reg[k]   <= {qy_reg[k-1][QB-2:0], gy[k]};
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign {den_f, px_f, py_f, posx_f, posy_f, vert_f, vx_f, last_f} = side_reg[QB];
    assign rmx = rx_reg[QB][NW-1:0];
    assign rmy = ry_reg[QB][NW-1:0];

    assign resx = vert_f ? RW'($signed(vx_f))
                         : round_coord(px_f, qx_reg[QB], rmx, den_f, posx_f);
    assign resy = vert_f ? RW'($signed(py_f))
                         : round_coord(py_f, qy_reg[QB], rmy, den_f, posy_f);
    assign clx  = clamp(resx);
    assign cly  = clamp(resy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            rvalid_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg   <= clx[C-1:0];
            my_reg   <= cly[C-1:0];
            eos_reg  <= last_f;
            clip_reg <= clx[C] | cly[C];
        end
    end

    assign res_valid    = rvalid_reg;
    assign mirrored_x   = mx_reg;
    assign mirrored_y   = my_reg;
    assign end_of_shape = eos_reg;
    assign clipped      = clip_reg;

endmodule

`default_nettype wire

// ===== rtl/core/point_reflect_across_line.sv =====
// throughput: one request per cycle while the queue is not full, set by the front product
//   stages and the divider pipeline that retires one quotient bit per stage
// a four-entry queue between front and divider absorbs output stalls
// reset: line endpoints return to (0,0)-(0,1), valid flags and queue pointers cleared
`default_nettype none

module point_reflect_across_line
    import pr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    pr_point_if.sink                   pt_in,
    pr_result_if.source                res_out,
    input  wire logic                  cfg_wr_en,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [COORD_BITS-1:0] cfg_wdata
);
    localparam int C  = COORD_BITS;
    localparam int EW = 2*(3*C + 5) + (2*C + 2) + 2*C + 3 + (C + 2) + 1;

    logic [C-1:0]  sx_reg, sy_reg, ex_reg, ey_reg;
    logic          front_en, f_valid, q_push, q_pop;
    logic [EW-1:0] f_entry, q_head;
    queue_stat_t   q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            ex_reg <= '0;
            ey_reg <= C'(1);
        end
        else if (cfg_wr_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_START_X: sx_reg <= cfg_wdata;
                REG_START_Y: sy_reg <= cfg_wdata;
                REG_END_X:   ex_reg <= cfg_wdata;
                REG_END_Y:   ey_reg <= cfg_wdata;
                default:     sx_reg <= sx_reg;
            endcase
        end
    end

    assign front_en    = !q_stat.full;
    assign pt_in.ready = front_en;
    assign q_push      = f_valid && front_en;

    pr_front #(.COORD_BITS(C)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (front_en),
        .in_valid   (pt_in.valid),
        .point_x    (pt_in.point_x),
        .point_y    (pt_in.point_y),
        .last_point (pt_in.last_point),
        .start_x    (sx_reg),
        .start_y    (sy_reg),
        .end_x      (ex_reg),
        .end_y      (ey_reg),
        .out_valid  (f_valid),
        .out_entry  (f_entry)
    );

    pr_queue #(.WIDTH(EW)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (f_entry),
        .pop   (q_pop),
        .rdata (q_head),
        .stat  (q_stat)
    );

    pr_back #(.COORD_BITS(C)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (!q_stat.empty),
        .q_entry      (q_head),
        .q_pop        (q_pop),
        .res_valid    (res_out.valid),
        .res_ready    (res_out.ready),
        .mirrored_x   (res_out.mirrored_x),
        .mirrored_y   (res_out.mirrored_y),
        .end_of_shape (res_out.end_of_shape),
        .clipped      (res_out.clipped)
    );

`ifndef SYNTHESIS
    a_queue_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |=> !q_stat.full)
        else $error("queue filled from empty in one cycle");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_point_reflect_across_line.sv =====
`timescale 1ns / 100ps

module tb_point_reflect_across_line;
    import pr_pkg::*;

    localparam int CB = 16;
    localparam longint CMAX = 32767;
    localparam longint CMIN = -32768;
    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [CB-1:0] mx;
        logic signed [CB-1:0] my;
        logic                 eos;
        logic                 clip;
    } mirrored_t;

    typedef struct {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic                 last;
        bit                   typed;
        mirrored_t            res;
    } vector_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [1:0] cfg_index;
    logic [CB-1:0] cfg_wdata;

    pr_point_if #(.COORD_BITS(CB)) pt ();
    pr_result_if #(.COORD_BITS(CB)) res ();

    point_reflect_across_line #(.COORD_BITS(CB)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_in     (pt),
        .res_out   (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    logic signed [CB-1:0] line_reg [4];
    mirrored_t pending_mirrors [$];
    int errors;
    int idle_cycles;
    bit rx_busy_stretch;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint round_coord(longint v, longint k, longint t, longint unsigned n);
        longint unsigned prod;
        longint unsigned qm;
        longint unsigned rm;
        bit pos;
        bit over;
        bit half;
        longint base;
        pos = (k < 0) == (t < 0);
        prod = magnitude(k) * magnitude(t);
        qm = prod / n;
        rm = prod % n;
        over = rm > n - rm;
        half = rm >= n - rm;
        if (rm == 0)
            return pos ? v - longint'(qm) : v + longint'(qm);
        if (pos)
        begin
            base = v - longint'(qm);
            return base - ((base <= 0) ? longint'(half) : longint'(over));
        end
        base = v + longint'(qm);
        return base + ((base >= 0) ? longint'(half) : longint'(over));
    endfunction

    function automatic longint saturate(longint v, ref bit clip);
        if (v > CMAX)
        begin
            clip = 1'b1;
            return CMAX;
        end
        if (v < CMIN)
        begin
            clip = 1'b1;
            return CMIN;
        end
        return v;
    endfunction

    function automatic mirrored_t mirror_point(logic signed [CB-1:0] px,
                                               logic signed [CB-1:0] py, logic last);
        longint x1, y1, x2, y2, a, b, d, rx, ry;
        longint unsigned n;
        bit clip;
        mirrored_t r;
        x1 = line_reg[REG_START_X];
        y1 = line_reg[REG_START_Y];
        x2 = line_reg[REG_END_X];
        y2 = line_reg[REG_END_Y];
        clip = 1'b0;
        if (x1 == x2)
        begin
            rx = 2 * x1 - longint'(px);
            ry = py;
        end
        else
        begin
            a = y2 - y1;
            b = x1 - x2;
            d = a * (longint'(px) - x1) + b * (longint'(py) - y1);
            n = longint'(a * a + b * b);
            rx = round_coord(px, a, 2 * d, n);
            ry = round_coord(py, b, 2 * d, n);
        end
        rx = saturate(rx, clip);
        ry = saturate(ry, clip);
        r.mx = rx[CB-1:0];
        r.my = ry[CB-1:0];
        r.eos = last;
        r.clip = clip;
        return r;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 13)
            return 0;
        if (sel < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                              logic last, bit typed, mirrored_t typed_res, int gap);
        if (gap > 0)
        begin
            pt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt.valid <= 1'b1;
        pt.point_x <= px;
        pt.point_y <= py;
        pt.last_point <= last;
        do
            @(posedge clk);
        while (!pt.ready);
        pending_mirrors.push_back(typed ? typed_res : mirror_point(px, py, last));
    endtask

    task automatic wait_drained();
        pt.valid <= 1'b0;
        @(posedge clk);
        while (pending_mirrors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_line(logic signed [CB-1:0] x1, logic signed [CB-1:0] y1,
                              logic signed [CB-1:0] x2, logic signed [CB-1:0] y2);
        logic signed [CB-1:0] vals [4];
        reg_idx_t idx;
        vals = '{x1, y1, x2, y2};
        wait_drained();
        for (int i = 0; i < 4; i++)
        begin
            idx = reg_idx_t'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= vals[i];
            @(posedge clk);
            line_reg[idx] = vals[i];
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [CB-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return CB'($urandom());
        if (sel < 7)
            return CB'($signed($urandom_range(0, 200)) - 100);
        if (sel < 8)
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        return CB'($signed($urandom_range(0, 4000)) - 2000);
    endfunction

    task automatic run_random(int count);
        mirrored_t none;
        bit busy;
        none = '{default: '0};
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                busy = $urandom_range(0, 3) == 0;
            if (i == count / 2 && $urandom_range(0, 1))
                wait_drained();
            send_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)), 1'b0, none,
                       busy ? 0 : pick_gap());
        end
    endtask

    // directed rows under the reset line, the y axis
    vector_t directed [] = '{
        '{16'sd0,     16'sd0,     1'b0, 1'b1, '{16'sd0,     16'sd0,     1'b0, 1'b0}},
        '{16'sh8000,  16'sd5,     1'b1, 1'b1, '{16'sd32767, 16'sd5,     1'b1, 1'b1}},
        '{16'sd32767, 16'sh8000,  1'b0, 1'b1, '{-16'sd32767, 16'sh8000, 1'b0, 1'b0}},
        '{16'sd1,     16'sd32767, 1'b1, 1'b1, '{-16'sd1,    16'sd32767, 1'b1, 1'b0}},
        '{-16'sd1,    -16'sd1,    1'b0, 1'b1, '{16'sd1,     -16'sd1,    1'b0, 1'b0}},
        '{16'sd1234,  -16'sd999,  1'b0, 1'b0, '{default: '0}},
        '{-16'sd32767, 16'sd0,    1'b1, 1'b0, '{default: '0}}
    };

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        pt.valid = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.last_point = 1'b0;
        errors = 0;
        line_reg[REG_START_X] = 0;
        line_reg[REG_START_Y] = 0;
        line_reg[REG_END_X] = 0;
        line_reg[REG_END_Y] = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_point(directed[i].px, directed[i].py, directed[i].last,
                       directed[i].typed, directed[i].res, i % 3);
        run_random(60);

        // line through the origin with slope one half; its norm is odd, so no exact halves occur
        write_line(16'sd0, 16'sd0, 16'sd2, 16'sd1);
        run_random(110);
        write_line(16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767);
        run_random(110);
        write_line(16'sd32767, 16'sh8000, 16'sh8000, 16'sd32767);
        run_random(110);
        // equal endpoints fold to a vertical mirror
        write_line(16'sd300, -16'sd20, 16'sd300, -16'sd20);
        run_random(90);
        write_line(16'sd32767, 16'sd5, 16'sd32767, 16'sh8000);
        run_random(90);
        write_line(16'sh8000, 16'sd7, 16'sd32767, 16'sd7);
        run_random(110);
        write_line(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        run_random(130);
        write_line(CB'($signed($urandom_range(0, 20)) - 10), CB'($signed($urandom_range(0, 20)) - 10),
                   CB'($signed($urandom_range(0, 20)) - 10), CB'($signed($urandom_range(0, 20)) - 10));
        run_random(130);

        wait_drained();
        if (errors == 0)
            $display("tb_point_reflect_across_line: PASS");
        else
            $display("tb_point_reflect_across_line: FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            rx_busy_stretch <= 1'b0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (pending_mirrors.size() == 0)
                begin
                    $display("%0t: unexpected result x=%0d y=%0d", $realtime,
                             res.mirrored_x, res.mirrored_y);
                    errors++;
                end
                else
                begin
                    if (res.mirrored_x !== pending_mirrors[0].mx ||
                        res.mirrored_y !== pending_mirrors[0].my ||
                        res.end_of_shape !== pending_mirrors[0].eos ||
                        res.clipped !== pending_mirrors[0].clip)
                    begin
                        $display("%0t: mismatch expected x=%0d y=%0d eos=%0b clip=%0b actual x=%0d y=%0d eos=%0b clip=%0b",
                                 $realtime, pending_mirrors[0].mx, pending_mirrors[0].my,
                                 pending_mirrors[0].eos, pending_mirrors[0].clip,
                                 res.mirrored_x, res.mirrored_y, res.end_of_shape, res.clipped);
                        errors++;
                    end
                    void'(pending_mirrors.pop_front());
                end
            end
            if ($urandom_range(0, 99) == 0)
                rx_busy_stretch <= ~rx_busy_stretch;
            if (rx_busy_stretch)
                res.ready <= 1'b1;
            else if ($urandom_range(0, 49) == 0)
                res.ready <= 1'b0;
            else if (!res.ready)
                res.ready <= $urandom_range(0, 9) == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
            else
                res.ready <= $urandom_range(0, 9) != 0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pt.valid && pt.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_point_reflect_across_line: FAIL");
            $finish;
        end
    end

endmodule
